/* hw/rtl/srcf_pkg.sv */
// ============================================================================
// srcf_pkg
// Shared types and constants for the shadow run center finder.
// ============================================================================
package srcf_pkg;

    localparam int MAX_PIXELS = 2048;
    localparam int POS_W      = 11;
    localparam int RUN_W      = 12;
    localparam int CNT_W      = 8;
    localparam int LIM_W      = 8;

    // Highest pixel index; the index saturates here on long frames.
    localparam logic [POS_W-1:0] TOP_INDEX =
        POS_W'(((MAX_PIXELS - 1) < 2047) ? (MAX_PIXELS - 1) : 2047);

    localparam logic [RUN_W-1:0] RUN_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [POS_W-1:0] RST_NOISE_WIDTH = POS_W'(3);
    localparam logic [POS_W-1:0] RST_MIN_WIDTH   = POS_W'(15);
    localparam logic [POS_W-1:0] RST_MAX_WIDTH   = POS_W'(63);
    localparam logic [LIM_W-1:0] RST_SMALL_LIMIT = LIM_W'(40);
    localparam logic [LIM_W-1:0] RST_LARGE_LIMIT = LIM_W'(10);

    typedef enum logic [2:0] {
        REG_NOISE_WIDTH = 3'd0,
        REG_MIN_WIDTH   = 3'd1,
        REG_MAX_WIDTH   = 3'd2,
        REG_SMALL_LIMIT = 3'd3,
        REG_LARGE_LIMIT = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_NONE      = 3'd0,
        ST_OK        = 3'd1,
        ST_SMALL     = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_NOISE     = 3'd4,
        ST_NUMEROUS  = 3'd5
    } t_status;

    typedef struct packed {
        logic [POS_W-1:0] noise_width;
        logic [POS_W-1:0] min_width;
        logic [POS_W-1:0] max_width;
        logic [LIM_W-1:0] small_limit;
        logic [LIM_W-1:0] large_limit;
    } t_cfg;

    typedef struct packed {
        logic             frame_ok;
        logic             position_valid;
        logic [POS_W-1:0] position;
        t_status          status;
    } t_result;

endpackage

/* hw/rtl/shadow_run_center_finder_unit.sv */
// ============================================================================
// shadow_run_center_finder_unit
// Measures dark pixel runs of a thresholded line sensor frame and reports
// the shadow center, status and axis at the last pixel of each frame.
// ============================================================================
// Throughput: one pixel per cycle unless a stall holds the last pixel of a
//   frame; the run/frame update is a single pass from the input register
//   into the frame state registers.
// The frame result passes the input register, then the result register,
//   before it can be taken.
// A pixel that closes a frame waits in the input register only while the
//   result register is still full and not taken.
// Reset (synchronous): clears frame state and both stages; limits return
//   to their defaults.
module shadow_run_center_finder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] pixel_level, [7:1] zero
    input  logic        i_s_tuser,   // [0] axis
    input  logic        i_s_tlast,   // frame_last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [2:0] status, [13:3] position,
                                     // [14] position_valid, [15] frame_ok
    output logic        o_m_tuser,   // [0] axis_out
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import srcf_pkg::*;

    t_cfg    cfg;
    t_result result;

    logic    r_in_valid;
    logic    r_in_level;
    logic    r_in_axis;
    logic    r_in_last;
    logic    step;

    logic    r_out_valid;
    t_result r_out_data;
    logic    r_out_axis;

    // Advance a pixel unless it ends a frame and the result slot is blocked.
    assign step       = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || step;

    srcf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    srcf_run_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_pixel_level (r_in_level),
        .i_frame_last  (r_in_last),
        .i_cfg         (cfg),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_level <= i_s_tdata[0];
            r_in_axis  <= i_s_tuser;
            r_in_last  <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out_data <= result;
            r_out_axis <= r_in_axis;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_axis;
    assign o_m_tdata  = {r_out_data.frame_ok, r_out_data.position_valid,
                         r_out_data.position, r_out_data.status};

endmodule

/* hw/rtl/srcf_cfg_regs.sv */
// ============================================================================
// srcf_cfg_regs
// APB register file for the run width limits and shadow count limits.
// ============================================================================
module srcf_cfg_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output srcf_pkg::t_cfg   o_cfg
);
    import srcf_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.noise_width <= RST_NOISE_WIDTH;
            r_cfg.min_width   <= RST_MIN_WIDTH;
            r_cfg.max_width   <= RST_MAX_WIDTH;
            r_cfg.small_limit <= RST_SMALL_LIMIT;
            r_cfg.large_limit <= RST_LARGE_LIMIT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NOISE_WIDTH: r_cfg.noise_width <= pwdata[POS_W-1:0];
                REG_MIN_WIDTH:   r_cfg.min_width   <= pwdata[POS_W-1:0];
                REG_MAX_WIDTH:   r_cfg.max_width   <= pwdata[POS_W-1:0];
                REG_SMALL_LIMIT: r_cfg.small_limit <= pwdata[LIM_W-1:0];
                REG_LARGE_LIMIT: r_cfg.large_limit <= pwdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NOISE_WIDTH: prdata = 32'(r_cfg.noise_width);
            REG_MIN_WIDTH:   prdata = 32'(r_cfg.min_width);
            REG_MAX_WIDTH:   prdata = 32'(r_cfg.max_width);
            REG_SMALL_LIMIT: prdata = 32'(r_cfg.small_limit);
            REG_LARGE_LIMIT: prdata = 32'(r_cfg.large_limit);
            default:         prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/srcf_run_core.sv */
// ============================================================================
// srcf_run_core
// Frame state and one-pixel update: run tracking, run classification,
// center position and the frame result on the last pixel.
// ============================================================================
module srcf_run_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_pixel_level,
    input  logic              i_frame_last,
    input  srcf_pkg::t_cfg    i_cfg,
    output srcf_pkg::t_result o_result
);
    import srcf_pkg::*;

    logic [POS_W-1:0] r_pixel_index, n_pixel_index;
    logic [POS_W-1:0] r_run_start,   n_run_start;
    logic [RUN_W-1:0] r_run_length,  n_run_length;
    logic [RUN_W-1:0] r_total,       n_total;
    logic [CNT_W-1:0] r_small_count, n_small_count;
    logic [CNT_W-1:0] r_large_count, n_large_count;
    t_status          r_last_status, n_last_status;
    logic [POS_W-1:0] r_center_pos,  n_center_pos;
    logic             r_center_valid, n_center_valid;
    logic             r_aborted,     n_aborted;

    logic             dark;
    logic [RUN_W-1:0] run_inc;
    logic [RUN_W-1:0] width;
    logic             closing;
    logic             counted;
    logic             is_small;
    logic             too_wide;
    logic             is_large;
    logic [RUN_W-1:0] sum;
    logic [RUN_W-1:0] pos_m1;
    logic [POS_W-1:0] center;
    logic [RUN_W-1:0] shadow_limit;
    t_status          status;

    assign dark    = !i_pixel_level;
    assign run_inc = (r_run_length == RUN_MAX) ? r_run_length : r_run_length + 1'b1;
    assign width   = dark ? run_inc : r_run_length;
    // A run closes on a lit pixel, or at the end of the frame.
    assign closing = !dark || i_frame_last;
    assign counted = closing && (width != '0) && !r_aborted;

    assign is_small = (width > RUN_W'(i_cfg.noise_width)) && (width < RUN_W'(i_cfg.min_width));
    assign too_wide = !is_small && (width > RUN_W'(i_cfg.max_width));
    assign is_large = !is_small && !too_wide && (width >= RUN_W'(i_cfg.min_width));

    assign n_run_start = (dark && (r_run_length == '0)) ? r_pixel_index : r_run_start;

    // Center is start + width/2 - 1, clamped to the index range.
    assign sum    = RUN_W'(n_run_start) + RUN_W'(width[RUN_W-1:1]);
    assign pos_m1 = (sum == '0) ? '0 : sum - 1'b1;
    assign center = (pos_m1 > RUN_W'(POS_MAX)) ? POS_MAX : pos_m1[POS_W-1:0];

    assign shadow_limit = RUN_W'(i_cfg.max_width) + RUN_W'(i_cfg.max_width[POS_W-1:1]);

    always_comb begin
        n_run_length   = closing ? '0 : width;
        n_total        = (dark && (r_total != RUN_MAX)) ? r_total + 1'b1 : r_total;
        n_small_count  = r_small_count;
        n_large_count  = r_large_count;
        n_last_status  = r_last_status;
        n_center_pos   = r_center_pos;
        n_center_valid = r_center_valid;
        n_aborted      = r_aborted;
        n_pixel_index  = (r_pixel_index < TOP_INDEX) ? r_pixel_index + 1'b1 : r_pixel_index;
        if (counted) begin
            if (is_small) begin
                if (r_small_count != CNT_MAX) n_small_count = r_small_count + 1'b1;
                n_last_status = ST_SMALL;
            end else if (too_wide || is_large) begin
                if (r_large_count != CNT_MAX) n_large_count = r_large_count + 1'b1;
                if (too_wide) begin
                    n_last_status = ST_TOO_LARGE;
                    n_aborted     = 1'b1;
                end else begin
                    n_last_status  = ST_OK;
                    n_center_pos   = center;
                    n_center_valid = 1'b1;
                end
            end
        end
    end

    always_comb begin
        priority if (n_aborted)
            status = ST_TOO_LARGE;
        else if ((n_total > shadow_limit) || (n_small_count > i_cfg.small_limit))
            status = ST_NOISE;
        else if (n_large_count > i_cfg.large_limit)
            status = ST_NUMEROUS;
        else
            status = n_last_status;
    end

    assign o_result.status         = status;
    assign o_result.position       = n_center_pos;
    assign o_result.position_valid = n_center_valid;
    assign o_result.frame_ok       = !((status == ST_TOO_LARGE) || (status == ST_NOISE) ||
                                       (status == ST_NUMEROUS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_frame_last)) begin
            // Clear all frame state after the frame result.
            r_pixel_index  <= '0;
            r_run_start    <= '0;
            r_run_length   <= '0;
            r_total        <= '0;
            r_small_count  <= '0;
            r_large_count  <= '0;
            r_last_status  <= ST_NONE;
            r_center_pos   <= '0;
            r_center_valid <= 1'b0;
            r_aborted      <= 1'b0;
        end else if (i_step) begin
            r_pixel_index  <= n_pixel_index;
            r_run_start    <= n_run_start;
            r_run_length   <= n_run_length;
            r_total        <= n_total;
            r_small_count  <= n_small_count;
            r_large_count  <= n_large_count;
            r_last_status  <= n_last_status;
            r_center_pos   <= n_center_pos;
            r_center_valid <= n_center_valid;
            r_aborted      <= n_aborted;
        end
    end

endmodule
